>>> hw/rtl/madt_pkg.sv
// Shared types, constants and helper functions for the MADT entry stream parser.
// Used by madt_parse_core, madt_result_fifo and madt_entry_stream_parser_unit.
// No dependencies.
package madt_pkg;

    // Capacity limits for stored CPUs and interrupt source overrides.
    localparam logic [6:0] CpuLimit      = 7'd64;
    localparam logic [4:0] OverrideLimit = 5'd16;

    // Result kinds.
    localparam logic [1:0] KindCpu      = 2'd0;
    localparam logic [1:0] KindIoApic   = 2'd1;
    localparam logic [1:0] KindOverride = 2'd2;
    localparam logic [1:0] KindEnd      = 2'd3;

    // Record types.
    localparam logic [7:0] RecLocalApic = 8'd0;
    localparam logic [7:0] RecIoApic    = 8'd1;
    localparam logic [7:0] RecOverride  = 8'd2;
    localparam logic [7:0] RecX2Apic    = 8'd9;

    // Table header layout.
    localparam logic [29:0] WordTableLength = 30'd1;   // bytes 4..7
    localparam logic [29:0] WordLocalApic   = 30'd9;   // bytes 36..39
    localparam logic [31:0] LengthKnownOffset = 32'd7;
    localparam logic [31:0] FirstRecordOffset = 32'd44;

    // Record layout.
    localparam logic [7:0] RecOffType   = 8'd0;
    localparam logic [7:0] RecOffLength = 8'd1;
    localparam logic [7:0] RecOffSmall  = 8'd3;
    localparam logic [5:0] WordFieldA   = 6'd1;        // record bytes 4..7
    localparam logic [5:0] WordFieldB   = 6'd2;        // record bytes 8..11
    localparam logic [7:0] MinRecordLength = 8'd2;
    localparam logic [7:0] X2ApicMinLength = 8'd16;

    // Result queue depth; it must hold at least two entries.
    localparam int ResultDepth = 4;
    localparam int ResultPtrW  = $clog2(ResultDepth);
    localparam int ResultCntW  = $clog2(ResultDepth + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       table_start;
    } madt_item_t;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [7:0]  apic_id;
        logic [6:0]  cpu_total;
        logic [31:0] io_apic_address;
        logic [7:0]  isa_irq;
        logic [31:0] global_irq;
        logic [15:0] override_flags;
        logic [4:0]  override_total;
        logic [31:0] local_apic_address;
        logic        bad_length_stop;
        logic        last;
    } madt_result_t;

    // Up to two results produced by one byte, in delivery order.
    typedef struct packed {
        logic [1:0]   count;
        madt_result_t first;
        madt_result_t second;
    } madt_push_t;

    function automatic madt_result_t blank_result(input logic [1:0]  kind,
                                                  input logic [6:0]  cpus,
                                                  input logic [4:0]  ovrs,
                                                  input logic [31:0] lapic);
        madt_result_t r;
        r = '0;
        r.record_kind        = kind;
        r.cpu_total          = cpus;
        r.override_total     = ovrs;
        r.local_apic_address = lapic;
        return r;
    endfunction

endpackage

>>> hw/rtl/madt_entry_stream_parser_unit.sv
// Top level of the MADT entry stream parser: input register and parser core,
// followed by a small result queue. Depends on madt_pkg, madt_parse_core and
// madt_result_fifo.
//
// Usage: the bytes of an MADT table enter on the item channel, one byte per
// transfer, with table_start set on the first byte of each table. Results leave
// on the result channel: a CPU added, an I/O APIC address, an override stored,
// and a table end; at most two per byte, the final one carrying last.
// A byte waits in the input register; its results are written into the queue.
// Throughput: one byte per cycle while item_stall is low. A byte that causes two
// results (a record closing on the table's final byte) does not slow the input;
// the queue drains them one per transfer.
// Stalling: while the receiver stalls, results collect in a four-entry queue;
// item_stall rises once fewer than two entries are free and a byte is waiting
// in the input register, so nothing is lost.
// Reset: clears both counts and the walk; the first byte after reset is taken
// as offset zero of a table. CPU and override counts persist across tables.
module madt_entry_stream_parser_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  madt_pkg::madt_item_t   item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output madt_pkg::madt_result_t result
);
    import madt_pkg::*;

    madt_push_t push;
    logic       room_two;

    madt_parse_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .room_two   (room_two),
        .push       (push)
    );

    madt_result_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room_two     (room_two),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // A table end is always the final result of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.record_kind == KindEnd |-> result.last)
        else $error("table end result without last");

    // The stop flag is only reported on a table end.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.record_kind != KindEnd |-> !result.bad_length_stop)
        else $error("bad length flag on a record result");

    // An APIC ID is only carried by a CPU result.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.record_kind != KindCpu |-> result.apic_id == 8'd0)
        else $error("APIC ID on a non-CPU result");

    // Counts saturate at their limits.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.cpu_total <= CpuLimit
                         && result.override_total <= OverrideLimit)
        else $error("count beyond its limit");

endmodule

>>> hw/rtl/madt_parse_core.sv
// Input register and single-pass byte parser of the MADT entry stream parser.
// Holds the table and record walk state; emits up to two results per byte.
// Depends on madt_pkg.
module madt_parse_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  madt_pkg::madt_item_t  item,
    input  logic                  room_two,
    output madt_pkg::madt_push_t  push
);
    import madt_pkg::*;

    logic        stage_valid_reg;
    madt_item_t  stage_item_reg;
    logic        fire;

    logic [31:0] offset_reg, tlen_reg, lapic_reg, fa_reg, fb_reg;
    logic [7:0]  rtype_reg, rlen_reg, roff_reg, sf_reg;
    logic        stopped_reg, ended_reg;
    logic [6:0]  cpu_cnt_reg;
    logic [4:0]  ovr_cnt_reg;

    logic [31:0] offset_next, tlen_next, lapic_next, fa_next, fb_next;
    logic [7:0]  rtype_next, rlen_next, roff_next, sf_next;
    logic        stopped_next, ended_next;
    logic [6:0]  cpu_cnt_next;
    logic [4:0]  ovr_cnt_next;

    logic [7:0]  b;
    logic        walk, finish, want_cpu, rec_hit, end_now;
    logic [1:0]  rec_kind;
    logic [7:0]  cpu_id;
    madt_result_t rec_res, end_res;

    assign item_stall = stage_valid_reg && !room_two;
    assign fire       = stage_valid_reg && room_two;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (item_valid && !item_stall)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            stage_item_reg <= item;
        end
    end

    always_comb
    begin
        b = stage_item_reg.data_byte;

        // A table start restarts the walk before this byte is looked at.
        if (stage_item_reg.table_start)
        begin
            offset_next  = '0;
            tlen_next    = '0;
            lapic_next   = '0;
            rtype_next   = '0;
            rlen_next    = '0;
            roff_next    = '0;
            fa_next      = '0;
            fb_next      = '0;
            sf_next      = '0;
            stopped_next = 1'b0;
            ended_next   = 1'b0;
        end
        else
        begin
            offset_next  = offset_reg;
            tlen_next    = tlen_reg;
            lapic_next   = lapic_reg;
            rtype_next   = rtype_reg;
            rlen_next    = rlen_reg;
            roff_next    = roff_reg;
            fa_next      = fa_reg;
            fb_next      = fb_reg;
            sf_next      = sf_reg;
            stopped_next = stopped_reg;
            ended_next   = ended_reg;
        end
        cpu_cnt_next = cpu_cnt_reg;
        ovr_cnt_next = ovr_cnt_reg;

        walk     = 1'b0;
        finish   = 1'b0;
        want_cpu = 1'b0;
        rec_hit  = 1'b0;
        end_now  = 1'b0;
        rec_kind = KindCpu;
        cpu_id   = '0;

        if (!ended_next)
        begin
            if (offset_next[31:2] == WordTableLength)
            begin
                tlen_next[{offset_next[1:0], 3'b000} +: 8] =
                    tlen_next[{offset_next[1:0], 3'b000} +: 8] | b;
            end
            else if (offset_next[31:2] == WordLocalApic)
            begin
                lapic_next[{offset_next[1:0], 3'b000} +: 8] =
                    lapic_next[{offset_next[1:0], 3'b000} +: 8] | b;
            end

            walk = (offset_next >= FirstRecordOffset) && (offset_next < tlen_next)
                   && !stopped_next;

            if (walk)
            begin
                if (roff_next == RecOffType)
                begin
                    rtype_next = b;
                    rlen_next  = '0;
                    fa_next    = '0;
                    fb_next    = '0;
                    sf_next    = '0;
                    roff_next  = RecOffLength;
                end
                else
                begin
                    if (roff_next == RecOffLength)
                    begin
                        rlen_next = b;
                    end
                    else if (roff_next == RecOffSmall)
                    begin
                        sf_next = b;
                    end
                    else if (roff_next[7:2] == WordFieldA)
                    begin
                        fa_next[{roff_next[1:0], 3'b000} +: 8] =
                            fa_next[{roff_next[1:0], 3'b000} +: 8] | b;
                    end
                    else if (roff_next[7:2] == WordFieldB)
                    begin
                        fb_next[{roff_next[1:0], 3'b000} +: 8] =
                            fb_next[{roff_next[1:0], 3'b000} +: 8] | b;
                    end

                    // A length below two cannot be walked past, so the walk ends here.
                    if (roff_next == RecOffLength && b < MinRecordLength)
                    begin
                        stopped_next = 1'b1;
                        roff_next    = RecOffType;
                    end
                    else if ({1'b0, roff_next} + 9'd1 >= {1'b0, rlen_next})
                    begin
                        roff_next = RecOffType;
                        finish    = 1'b1;
                    end
                    else
                    begin
                        roff_next = roff_next + 8'd1;
                    end
                end
            end

            if (finish)
            begin
                unique case (rtype_next)
                    RecLocalApic:
                    begin
                        want_cpu = fa_next[1:0] != 2'b00;
                        cpu_id   = sf_next;
                    end
                    RecX2Apic:
                    begin
                        want_cpu = (rlen_next >= X2ApicMinLength) && (fb_next[1:0] != 2'b00);
                        cpu_id   = fa_next[7:0];
                    end
                    RecIoApic:
                    begin
                        rec_hit  = 1'b1;
                        rec_kind = KindIoApic;
                    end
                    RecOverride:
                    begin
                        if (ovr_cnt_reg < OverrideLimit)
                        begin
                            ovr_cnt_next = ovr_cnt_reg + 5'd1;
                            rec_hit      = 1'b1;
                            rec_kind     = KindOverride;
                        end
                    end
                    default:
                    begin
                        want_cpu = 1'b0;
                    end
                endcase

                if (want_cpu && cpu_cnt_reg < CpuLimit)
                begin
                    cpu_cnt_next = cpu_cnt_reg + 7'd1;
                    rec_hit      = 1'b1;
                    rec_kind     = KindCpu;
                end
            end

            end_now = (offset_next >= LengthKnownOffset)
                      && ({1'b0, offset_next} + 33'd1 >= {1'b0, tlen_next});
            if (end_now)
            begin
                ended_next = 1'b1;
            end
            else if (offset_next != '1)
            begin
                offset_next = offset_next + 32'd1;
            end
        end

        rec_res = blank_result(rec_kind, cpu_cnt_next, ovr_cnt_next, lapic_next);
        unique case (rec_kind)
            KindCpu:
            begin
                rec_res.apic_id = cpu_id;
            end
            KindIoApic:
            begin
                rec_res.io_apic_address = fa_next;
            end
            KindOverride:
            begin
                rec_res.isa_irq        = sf_next;
                rec_res.global_irq     = fa_next;
                rec_res.override_flags = fb_next[15:0];
            end
            default:
            begin
                rec_res.bad_length_stop = 1'b0;
            end
        endcase

        end_res = blank_result(KindEnd, cpu_cnt_next, ovr_cnt_next, lapic_next);
        end_res.bad_length_stop = stopped_next;
        end_res.last            = 1'b1;

        push = '0;
        if (fire)
        begin
            if (rec_hit && end_now)
            begin
                push.count  = 2'd2;
                push.first  = rec_res;
                push.second = end_res;
            end
            else if (rec_hit)
            begin
                push.count      = 2'd1;
                push.first      = rec_res;
                push.first.last = 1'b1;
            end
            else if (end_now)
            begin
                push.count = 2'd1;
                push.first = end_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            tlen_reg    <= '0;
            lapic_reg   <= '0;
            rtype_reg   <= '0;
            rlen_reg    <= '0;
            roff_reg    <= '0;
            fa_reg      <= '0;
            fb_reg      <= '0;
            sf_reg      <= '0;
            stopped_reg <= 1'b0;
            ended_reg   <= 1'b0;
            cpu_cnt_reg <= '0;
            ovr_cnt_reg <= '0;
        end
        else if (fire)
        begin
            offset_reg  <= offset_next;
            tlen_reg    <= tlen_next;
            lapic_reg   <= lapic_next;
            rtype_reg   <= rtype_next;
            rlen_reg    <= rlen_next;
            roff_reg    <= roff_next;
            fa_reg      <= fa_next;
            fb_reg      <= fb_next;
            sf_reg      <= sf_next;
            stopped_reg <= stopped_next;
            ended_reg   <= ended_next;
            cpu_cnt_reg <= cpu_cnt_next;
            ovr_cnt_reg <= ovr_cnt_next;
        end
    end

endmodule

>>> hw/rtl/madt_result_fifo.sv
// Small result queue of the MADT entry stream parser: takes up to two results
// per cycle from the parser and delivers one per transfer. Depends on madt_pkg.
module madt_result_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  madt_pkg::madt_push_t   push,
    output logic                   room_two,
    output logic                   result_valid,
    input  logic                   result_stall,
    output madt_pkg::madt_result_t result
);
    import madt_pkg::*;

    madt_result_t            mem [ResultDepth];
    logic [ResultPtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [ResultPtrW-1:0]   wr_ptr_next, rd_ptr_next, wr_ptr_plus;
    logic [ResultCntW-1:0]   count_reg, count_next;
    logic                    pop;

    assign result_valid = count_reg != '0;
    assign result       = mem[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;
    // Room is judged on the registered fill so that it never waits on the receiver.
    assign room_two     = count_reg <= ResultCntW'(ResultDepth - 2);

    assign wr_ptr_plus = wr_ptr_reg + ResultPtrW'(1);
    assign wr_ptr_next = wr_ptr_reg + ResultPtrW'(push.count);
    assign rd_ptr_next = pop ? rd_ptr_reg + ResultPtrW'(1) : rd_ptr_reg;
    assign count_next  = count_reg + ResultCntW'(push.count) - ResultCntW'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_plus] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> tb/sv/madt_check_pkg.sv
// Scoreboard for the MADT entry stream parser: an independent byte-by-byte
// predictor of the parser and the store of results it still awaits.
// Depends on madt_pkg for the item and result types and the layout constants.
package madt_check_pkg;

    import madt_pkg::*;

    class madt_scoreboard;

        madt_result_t awaited_q[$];
        madt_result_t byte_results[$];
        int unsigned  mismatches;

        // Per-table walk state.
        logic [31:0] offset;
        logic [31:0] tab_len;
        logic [31:0] lapic;
        logic [31:0] fld_a;
        logic [31:0] fld_b;
        logic [7:0]  rec_type;
        logic [7:0]  rec_len;
        logic [7:0]  rec_off;
        logic [7:0]  small_b;
        bit          stopped;
        bit          ended;

        // Counts survive table starts; only reset clears them.
        logic [6:0]  cpus;
        logic [4:0]  ovrs;

        function new();
            mismatches = 0;
            cpus = '0;
            ovrs = '0;
            restart_walk();
        endfunction

        function void restart_walk();
            offset   = '0;
            tab_len  = '0;
            lapic    = '0;
            fld_a    = '0;
            fld_b    = '0;
            rec_type = '0;
            rec_len  = '0;
            rec_off  = '0;
            small_b  = '0;
            stopped  = 1'b0;
            ended    = 1'b0;
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        function madt_result_t fresh(logic [1:0] kind);
            madt_result_t r;
            r = '0;
            r.record_kind        = kind;
            r.cpu_total          = cpus;
            r.override_total     = ovrs;
            r.local_apic_address = lapic;
            return r;
        endfunction

        function void close_record();
            bit           want_cpu;
            logic [7:0]   id;
            madt_result_t r;
            want_cpu = 1'b0;
            id = '0;
            case (rec_type)
                RecLocalApic:
                begin
                    want_cpu = fld_a[1:0] != 2'b00;
                    id = small_b;
                end
                RecX2Apic:
                begin
                    want_cpu = rec_len >= X2ApicMinLength && fld_b[1:0] != 2'b00;
                    id = fld_a[7:0];
                end
                RecIoApic:
                begin
                    r = fresh(KindIoApic);
                    r.io_apic_address = fld_a;
                    byte_results.push_back(r);
                    return;
                end
                RecOverride:
                begin
                    if (ovrs < OverrideLimit)
                    begin
                        ovrs++;
                        r = fresh(KindOverride);
                        r.isa_irq        = small_b;
                        r.global_irq     = fld_a;
                        r.override_flags = fld_b[15:0];
                        byte_results.push_back(r);
                    end
                    return;
                end
                default:
                    return;
            endcase
            if (want_cpu && cpus < CpuLimit)
            begin
                cpus++;
                r = fresh(KindCpu);
                r.apic_id = id;
                byte_results.push_back(r);
            end
        endfunction

        function void walk_byte(logic [7:0] b);
            logic [7:0] ro;
            ro = rec_off;
            if (ro == RecOffType)
            begin
                rec_type = b;
                rec_len  = '0;
                fld_a    = '0;
                fld_b    = '0;
                small_b  = '0;
            end
            else if (ro == RecOffLength)
            begin
                rec_len = b;
                // A length below two ends the walk for the rest of the table.
                if (b < MinRecordLength)
                begin
                    stopped = 1'b1;
                    rec_off = '0;
                    return;
                end
            end
            else if (ro == RecOffSmall)
                small_b = b;
            else if (ro >= 8'd4 && ro <= 8'd7)
                fld_a |= {24'h0, b} << (8 * (ro - 8'd4));
            else if (ro >= 8'd8 && ro <= 8'd11)
                fld_b |= {24'h0, b} << (8 * (ro - 8'd8));

            if (ro >= RecOffLength && {1'b0, ro} + 9'd1 >= {1'b0, rec_len})
            begin
                rec_off = '0;
                close_record();
            end
            else
                rec_off = ro + 8'd1;
        endfunction

        // Works out what one accepted byte transfer causes.
        function void note_item(madt_item_t it);
            logic [7:0]   b;
            logic [31:0]  o;
            madt_result_t r;
            b = it.data_byte;
            byte_results.delete();
            if (it.table_start)
                restart_walk();
            if (ended)
                return;
            o = offset;
            if (o >= 32'd4 && o <= 32'd7)
                tab_len |= {24'h0, b} << (8 * (o - 32'd4));
            else if (o >= 32'd36 && o <= 32'd39)
                lapic |= {24'h0, b} << (8 * (o - 32'd36));

            if (o >= FirstRecordOffset && o < tab_len && !stopped)
                walk_byte(b);

            if (o >= LengthKnownOffset && {1'b0, o} + 33'd1 >= {1'b0, tab_len})
            begin
                r = fresh(KindEnd);
                r.bad_length_stop = stopped;
                byte_results.push_back(r);
                ended = 1'b1;
            end
            else if (o != 32'hFFFF_FFFF)
                offset = o + 32'd1;

            if (byte_results.size() > 0)
                byte_results[byte_results.size() - 1].last = 1'b1;
            foreach (byte_results[i])
                awaited_q.push_back(byte_results[i]);
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= 100)
                    $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
            end
        endfunction

        function void check_result(madt_result_t got);
            madt_result_t want;
            if (awaited_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 100)
                    $display("%0t: result with none expected, actual kind %0d",
                             $time, got.record_kind);
                return;
            end
            want = awaited_q.pop_front();
            cmp_field("record_kind", 32'(want.record_kind), 32'(got.record_kind));
            cmp_field("apic_id", 32'(want.apic_id), 32'(got.apic_id));
            cmp_field("cpu_total", 32'(want.cpu_total), 32'(got.cpu_total));
            cmp_field("io_apic_address", want.io_apic_address, got.io_apic_address);
            cmp_field("isa_irq", 32'(want.isa_irq), 32'(got.isa_irq));
            cmp_field("global_irq", want.global_irq, got.global_irq);
            cmp_field("override_flags", 32'(want.override_flags), 32'(got.override_flags));
            cmp_field("override_total", 32'(want.override_total), 32'(got.override_total));
            cmp_field("local_apic_address", want.local_apic_address,
                      got.local_apic_address);
            cmp_field("bad_length_stop", 32'(want.bad_length_stop),
                      32'(got.bad_length_stop));
            cmp_field("last", 32'(want.last), 32'(got.last));
        endfunction

    endclass

endpackage

>>> tb/sv/tb.sv
// Top of the MADT parser testbench: clock, reset, byte and result drivers,
// table generation and the final verdict.
// Depends on madt_pkg, madt_check_pkg and madt_entry_stream_parser_unit.
module tb;

    import madt_pkg::*;
    import madt_check_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int LongHold      = 150;
    localparam int CalmBytes     = 150;
    localparam int StyleNormal   = 0;
    localparam int StyleDense    = 1;
    localparam int StyleNoise    = 2;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         item_valid = 1'b0;
    logic         item_stall;
    madt_item_t   item = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    madt_result_t result;

    madt_scoreboard sb;
    logic [7:0]     table_bytes[$];
    int             bytes_sent;
    int             quiet_cycles;
    int             hold_left;
    bit             hold_request;
    bit             calm;

    madt_entry_stream_parser_unit dut (.*);

    always #5 clk = ~clk;

    // Transfers are sampled with the values from just before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                sb.note_item(item);
            if (result_valid && !result_stall)
                sb.check_result(result);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WatchdogLimit)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Receiver: occasional stalls, none while calm, and one long hold on request.
    initial
    begin
        hold_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LongHold;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !calm && ($urandom_range(99) < 6);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic s);
        int gap;
        if (!calm && $urandom_range(99) < 6)
        begin
            gap = $urandom_range(1, 4);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= '{data_byte: b, table_start: s};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Stops offering bytes until every awaited result has been delivered.
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic add_record(input int pick);
        logic [7:0] kind;
        int         len;
        if (pick < 35)
        begin
            kind = RecLocalApic;
            len = ($urandom_range(3) == 0) ? $urandom_range(2, 12) : 8;
        end
        else if (pick < 50)
        begin
            kind = RecX2Apic;
            len = ($urandom_range(2) == 0) ? $urandom_range(2, 20) : 16;
        end
        else if (pick < 60)
        begin
            kind = RecIoApic;
            len = ($urandom_range(3) == 0) ? $urandom_range(2, 14) : 12;
        end
        else if (pick < 85)
        begin
            kind = RecOverride;
            len = ($urandom_range(3) == 0) ? $urandom_range(2, 12) : 10;
        end
        else if (pick < 96)
        begin
            // Unknown types are skipped; now and then a very long one.
            kind = 8'($urandom_range(3, 255));
            if (kind == RecX2Apic)
                kind = 8'd3;
            len = ($urandom_range(19) == 0) ? $urandom_range(2, 255) : $urandom_range(2, 24);
        end
        else
        begin
            kind = 8'($urandom);
            len = $urandom_range(0, 1);
        end
        table_bytes.push_back(kind);
        table_bytes.push_back(8'(len));
        repeat ((len > 2) ? len - 2 : 0)
            table_bytes.push_back(8'($urandom));
    endtask

    task automatic build_table(input int style);
        int len;
        int v;
        int keep;
        int i;
        table_bytes.delete();
        if (style == StyleNoise)
        begin
            repeat ($urandom_range(20, 100))
                table_bytes.push_back(8'($urandom));
            return;
        end
        repeat (44)
            table_bytes.push_back(8'($urandom));
        if (style == StyleDense)
        begin
            keep = $urandom_range(1);
            repeat ($urandom_range(10, 20))
                add_record(keep ? $urandom_range(60, 84) : $urandom_range(0, 34));
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                add_record($urandom_range(99));
        end
        len = table_bytes.size();
        v = $urandom_range(99);
        if (v < 8)
            len = $urandom_range(45, len - 1);   // last record cut off by the table end
        else if (v < 18)
            len = $urandom_range(0, 43);         // table ends inside the header
        for (i = 0; i < 4; i++)
            table_bytes[4 + i] = 8'(len >> (8 * i));
        if (v < 18)
        begin
            // Keep only a few bytes past the end; they should be ignored.
            keep = ((len > 8) ? len : 8) + $urandom_range(0, 3);
            while (table_bytes.size() > keep)
                void'(table_bytes.pop_back());
        end
        else if (v < 24)
        begin
            repeat ($urandom_range(1, 4))
                table_bytes.push_back(8'($urandom));
        end
        else if (v < 30)
        begin
            // The next table start cuts this one short.
            keep = $urandom_range(8, table_bytes.size() - 1);
            while (table_bytes.size() > keep)
                void'(table_bytes.pop_back());
        end
    endtask

    task automatic send_table(input bit noisy);
        int i;
        for (i = 0; i < table_bytes.size(); i++)
            send_byte(table_bytes[i], (i == 0) || (noisy && $urandom_range(99) < 3));
    endtask

    initial
    begin
        int tables;
        int pick;
        int calm_start;
        sb = new();
        bytes_sent = 0;
        quiet_cycles = 0;
        hold_request = 1'b0;
        calm = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // The first byte after reset is offset zero even without table_start.
        // Length zero: the table end comes at offset seven.
        send_byte(8'hFF, 1'b0);
        repeat (7) send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Length nine: the end comes on the ninth byte.
        send_byte(8'h00, 1'b1);
        repeat (3) send_byte(8'hFF, 1'b0);
        send_byte(8'd9, 1'b0);
        repeat (3) send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // An all-ones length outlasts these bytes; the next table start abandons it.
        send_byte(8'hFF, 1'b1);
        repeat (7) send_byte(8'hFF, 1'b0);
        drain();

        // A stretch with no idling on either side.
        calm = 1'b1;
        calm_start = bytes_sent;
        while (bytes_sent - calm_start < CalmBytes)
        begin
            build_table(StyleNormal);
            send_table(1'b0);
        end
        calm = 1'b0;

        // Hold the receiver off while bytes keep arriving. The short tables
        // each end at offset seven, so the result queue is sure to fill.
        hold_request = 1'b1;
        repeat (8)
        begin
            send_byte(8'h00, 1'b1);
            repeat (7) send_byte(8'h00, 1'b0);
        end
        build_table(StyleDense);
        send_table(1'b0);

        tables = 0;
        while (bytes_sent < 500)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                build_table(StyleNormal);
            else if (pick < 88)
                build_table(StyleDense);
            else
                build_table(StyleNoise);
            send_table(pick >= 88);
            tables++;
            if (tables % 10 == 0)
                drain();
        end

        drain();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/madt_pkg.sv
hw/rtl/madt_parse_core.sv
hw/rtl/madt_result_fifo.sv
hw/rtl/madt_entry_stream_parser_unit.sv
tb/sv/madt_check_pkg.sv
tb/sv/tb.sv
